/* sv/csl_pkg.sv */
// ----------------------------------------------------------------------------
// csl_pkg
// shared types and constants of the c subset lexer
// ----------------------------------------------------------------------------
`default_nettype none
package csl_pkg;
	localparam int MAX_TEXT = 255;
	localparam int LINE_BITS = 16;
	localparam int COLUMN_BITS = 12;
	localparam int OFFSET_BITS = 20;

	typedef enum logic [2:0] {
		M_IDLE, M_NUMBER, M_IDENT, M_OPER, M_SLASH, M_LINE, M_BLOCK, M_BSTAR
	} scan_mode_t;

	localparam logic [5:0] K_END = 6'd0;
	localparam logic [5:0] K_ERROR = 6'd1;
	localparam logic [5:0] K_NUMBER = 6'd2;
	localparam logic [5:0] K_IDENT = 6'd3;
	localparam logic [5:0] K_DIV = 6'd14;

	typedef struct packed {
		logic [5:0] kind;
		logic [LINE_BITS-1:0] line;
		logic [COLUMN_BITS-1:0] column;
		logic [OFFSET_BITS-1:0] offset;
		logic [7:0] length;
		logic [7:0] err;
		logic last;
	} token_t;

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		unique case (c)
			8'h2b: return 6'd11;
			8'h2d: return 6'd12;
			8'h2a: return 6'd13;
			8'h2f: return 6'd14;
			8'h25: return 6'd15;
			8'h28: return 6'd16;
			8'h29: return 6'd17;
			8'h7b: return 6'd18;
			8'h7d: return 6'd19;
			8'h5b: return 6'd20;
			8'h5d: return 6'd21;
			8'h3b: return 6'd22;
			8'h2c: return 6'd23;
			8'h2e: return 6'd24;
			8'h3d: return 6'd26;
			8'h21: return 6'd28;
			8'h3c: return 6'd30;
			8'h3e: return 6'd32;
			default: return K_ERROR;
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] c);
		unique case (c)
			8'h3d: return 6'd25;
			8'h21: return 6'd27;
			8'h3c: return 6'd29;
			8'h3e: return 6'd31;
			8'h26: return 6'd33;
			default: return 6'd34;
		endcase
	endfunction

	function automatic logic [5:0] word_kind(input logic [47:0] p, input logic [7:0] n);
		if (n == 8'd3 && p == 48'h746e69) return 6'd4;
		if (n == 8'd6 && p == 48'h6e7275746572) return 6'd5;
		if (n == 8'd2 && p == 48'h6669) return 6'd6;
		if (n == 8'd4 && p == 48'h65736c65) return 6'd7;
		if (n == 8'd5 && p == 48'h656c696877) return 6'd8;
		if (n == 8'd3 && p == 48'h726f66) return 6'd9;
		if (n == 8'd4 && p == 48'h64696f76) return 6'd10;
		return K_IDENT;
	endfunction
endpackage
`default_nettype wire

/* sv/csl_queue.sv */
// ----------------------------------------------------------------------------
// csl_queue
// small token queue between scanner and output
// ----------------------------------------------------------------------------
`default_nettype none
module csl_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire csl_pkg::token_t wr_data,
	output logic [2:0] count,
	input wire logic rd_en,
	output csl_pkg::token_t rd_data
);
	import csl_pkg::*;
	token_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (rd_en) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr_en} - {2'd0, rd_en};
		end
	end
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end
	assign rd_data = mem_q[rp_q];
	assign count = cnt_q;
endmodule
`default_nettype wire

/* sv/csl_scan.sv */
// ----------------------------------------------------------------------------
// csl_scan
// front scanner: accepts one byte a request, emits up to two tokens
// ----------------------------------------------------------------------------
`default_nettype none
module csl_scan (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic take,
	input wire logic [7:0] c,
	output logic n0,
	output logic n1,
	output csl_pkg::token_t t0,
	output csl_pkg::token_t t1
);
	import csl_pkg::*;
	localparam logic [LINE_BITS-1:0] LTOP = '1;
	localparam logic [COLUMN_BITS-1:0] CTOP = '1;
	localparam logic [OFFSET_BITS-1:0] OTOP = '1;

	scan_mode_t mode_q, mode_d;
	logic [7:0] pend_q, pend_d, len_q, len_d;
	logic [47:0] pre_q, pre_d;
	logic [LINE_BITS-1:0] tl_q, tl_d, ln_q;
	logic [COLUMN_BITS-1:0] tc_q, tc_d, cn_q;
	logic [OFFSET_BITS-1:0] to_q, to_d, bo_q;
	logic fl, bg, isd, isa, isw, iss, pairm;
	token_t ft, bt, et;
	logic [5:0] sk, bk;

	always_comb begin
		isd = c >= 8'h30 && c <= 8'h39;
		isa = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
		isw = isd || isa || c == 8'h5f;
		iss = c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
		pairm = (pend_q == 8'h26 || pend_q == 8'h7c) ? c == pend_q : c == 8'h3d;
		sk = single_kind(pend_q);
		bk = single_kind(c);
		ft = '0;
		ft.line = tl_q;
		ft.column = tc_q;
		ft.offset = to_q;
		ft.length = 8'd1;
		unique case (mode_q)
			M_NUMBER: begin ft.kind = K_NUMBER; ft.length = len_q; end
			M_IDENT: begin ft.kind = word_kind(pre_q, len_q); ft.length = len_q; end
			M_OPER: begin ft.kind = sk; ft.err = (sk == K_ERROR) ? pend_q : 8'd0; end
			default: ft.kind = K_DIV;
		endcase
		bt = '0;
		bt.line = ln_q;
		bt.column = cn_q;
		bt.offset = bo_q;
		bt.length = 8'd1;
		bt.kind = bk;
		bt.err = (bk == K_ERROR) ? c : 8'd0;
		et = '0;
		et.kind = K_END;
		et.line = ln_q;
		et.column = cn_q;
		et.offset = bo_q;
		et.last = 1'b1;

		mode_d = mode_q; pend_d = pend_q; pre_d = pre_q; len_d = len_q;
		tl_d = tl_q; tc_d = tc_q; to_d = to_q;
		fl = 1'b0; bg = 1'b0;
		n0 = 1'b0; n1 = 1'b0; t0 = ft; t1 = et;
		if (c == 8'd0) begin
			fl = mode_q == M_NUMBER || mode_q == M_IDENT || mode_q == M_OPER
				|| mode_q == M_SLASH;
		end else begin
			unique case (mode_q)
				M_NUMBER, M_IDENT: begin
					if ((mode_q == M_NUMBER) ? isd : isw) begin
						if (len_q < 8'(MAX_TEXT)) begin
							if (len_q < 8'd6) pre_d = pre_q | (48'(c) << {len_q[2:0], 3'b000});
							len_d = len_q + 8'd1;
						end
					end else begin fl = 1'b1; bg = 1'b1; end
				end
				M_OPER: begin
					if (pairm) begin
						n0 = 1'b1;
						t0 = ft;
						t0.kind = pair_kind(pend_q);
						t0.length = 8'd2;
						t0.err = 8'd0;
						mode_d = M_IDLE; pend_d = '0; len_d = '0;
					end else begin fl = 1'b1; bg = 1'b1; end
				end
				M_SLASH: begin
					if (c == 8'h2f) begin mode_d = M_LINE; len_d = '0; end
					else if (c == 8'h2a) begin mode_d = M_BLOCK; len_d = '0; end
					else begin fl = 1'b1; bg = 1'b1; end
				end
				M_LINE: if (c == 8'h0a) mode_d = M_IDLE;
				M_BLOCK: if (c == 8'h2a) mode_d = M_BSTAR;
				M_BSTAR: begin
					if (c == 8'h2f) mode_d = M_IDLE;
					else if (c != 8'h2a) mode_d = M_BLOCK;
				end
				default: bg = 1'b1;
			endcase
		end
		if (fl) begin
			n0 = 1'b1; t0 = ft;
			mode_d = M_IDLE; pend_d = '0; pre_d = '0; len_d = '0;
		end
		if (c == 8'd0) begin
			if (fl) n1 = 1'b1; else begin n0 = 1'b1; t0 = et; end
		end
		if (bg) begin
			mode_d = M_IDLE;
			if (!iss) begin
				if (isd || isa || c == 8'h5f || c == 8'h2f || c == 8'h3d || c == 8'h21
					|| c == 8'h3c || c == 8'h3e || c == 8'h26 || c == 8'h7c) begin
					tl_d = ln_q; tc_d = cn_q; to_d = bo_q; len_d = 8'd1;
					if (isd) mode_d = M_NUMBER;
					else if (isa || c == 8'h5f) begin mode_d = M_IDENT; pre_d = 48'(c); end
					else if (c == 8'h2f) mode_d = M_SLASH;
					else begin mode_d = M_OPER; pend_d = c; end
				end else if (fl) begin
					n1 = 1'b1; t1 = bt;
				end else begin
					n0 = 1'b1; t0 = bt;
				end
			end
		end
		if (n1) t1.last = 1'b1;
		else t0.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= '0; pre_q <= '0; len_q <= '0;
			tl_q <= LINE_BITS'(1); tc_q <= COLUMN_BITS'(1); to_q <= '0;
			ln_q <= LINE_BITS'(1); cn_q <= COLUMN_BITS'(1); bo_q <= '0;
		end else if (take) begin
			if (c == 8'd0) begin
				mode_q <= M_IDLE; pend_q <= '0; pre_q <= '0; len_q <= '0;
				tl_q <= LINE_BITS'(1); tc_q <= COLUMN_BITS'(1); to_q <= '0;
				ln_q <= LINE_BITS'(1); cn_q <= COLUMN_BITS'(1); bo_q <= '0;
			end else begin
				mode_q <= mode_d; pend_q <= pend_d; pre_q <= pre_d; len_q <= len_d;
				tl_q <= tl_d; tc_q <= tc_d; to_q <= to_d;
				if (c == 8'h0a) begin
					if (ln_q != LTOP) ln_q <= ln_q + LINE_BITS'(1);
					cn_q <= COLUMN_BITS'(1);
				end else if (cn_q != CTOP) cn_q <= cn_q + COLUMN_BITS'(1);
				if (bo_q != OTOP) bo_q <= bo_q + OFFSET_BITS'(1);
			end
		end
	end
endmodule
`default_nettype wire

/* sv/c_subset_lexer_core.sv */
// ----------------------------------------------------------------------------
// c_subset_lexer_core
// one source byte a cycle in while ready_in is high, tokens out through a four entry queue
// a token is registered in staging and then in the queue before it appears at the output
// one byte is accepted a cycle while tokens drain; a byte that causes two
// tokens holds the input while its second token waits in staging
// reset clears scan state, positions (line and column to 1) and the queue
// ----------------------------------------------------------------------------
`default_nettype none
module c_subset_lexer_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid_in,
	output logic ready_in,
	input wire logic [7:0] source_byte,
	output logic valid_out,
	input wire logic ready_out,
	output logic [5:0] token_kind,
	output logic [15:0] start_line,
	output logic [11:0] start_column,
	output logic [19:0] start_offset,
	output logic [7:0] text_length,
	output logic [7:0] error_char,
	output logic last_of_run
);
	import csl_pkg::*;
	logic take, n0, n1, rd;
	token_t t0, t1, rdd, w0_s1, w1_s1, wd;
	logic v0_s1, v1_s1, wr;
	logic [2:0] cnt;

	// free slots must cover the staged tokens and the two new tokens of a request
	assign ready_in = cnt + {2'd0, v0_s1} + {2'd0, v1_s1} <= 3'd2 && !(v0_s1 && v1_s1);
	assign take = valid_in && ready_in;

	csl_scan u_scan (
		.clk(clk), .arst_n(arst_n), .take(take), .c(source_byte),
		.n0(n0), .n1(n1), .t0(t0), .t1(t1)
	);

	// staging: one token written to queue per cycle
	assign wr = v0_s1;
	assign wd = w0_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_s1 <= 1'b0; v1_s1 <= 1'b0;
		end else begin
			if (v1_s1) begin
				v0_s1 <= 1'b1; v1_s1 <= 1'b0;
			end else if (take && n0) begin
				v0_s1 <= 1'b1; v1_s1 <= n1;
			end else v0_s1 <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (v1_s1) w0_s1 <= w1_s1;
		else if (take) begin w0_s1 <= t0; w1_s1 <= t1; end
	end

	assign valid_out = cnt != 3'd0;
	assign rd = valid_out && ready_out;
	csl_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(wr), .wr_data(wd),
		.count(cnt), .rd_en(rd), .rd_data(rdd)
	);

	assign token_kind = rdd.kind;
	assign start_line = rdd.line;
	assign start_column = rdd.column;
	assign start_offset = rdd.offset;
	assign text_length = rdd.length;
	assign error_char = rdd.err;
	assign last_of_run = rdd.last;
endmodule
`default_nettype wire
